// File: design/complex_arith_unit_core_assert.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_SAME(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);
`define CAU_ASSERT_NEXT(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);
`else
`define CAU_ASSERT_SAME(lbl, clk, rst, ant, con, msg)
`define CAU_ASSERT_NEXT(lbl, clk, rst, ant, con, msg)
`endif
`endif

// File: design/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
   localparam int DW = 16;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int QW = DW + 1;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic signed [DW-1:0] a_re;
      logic signed [DW-1:0] a_im;
      logic signed [DW-1:0] b_re;
      logic signed [DW-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_re;
      logic signed [DW-1:0] res_im;
      logic                 overflow;
      logic                 div_zero;
   } rsp_type;

   // One part of a division in flight: remainder, dividend bits still to
   // enter, quotient so far and a flag for quotient bits lost off the top.
   typedef struct packed {
      logic [SW-1:0] n;
      logic [PW-1:0] rem;
      logic [QW-1:0] q;
      logic          big;
   } div_part_type;

   typedef struct packed {
      logic          div;
      logic          dz;
      logic          neg_re;
      logic          neg_im;
      logic [SW-1:0] mag_re;
      logic [SW-1:0] mag_im;
      logic [PW-1:0] den;
      div_part_type  dre;
      div_part_type  dim;
   } cell_type;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          ov;
   } sat_type;

   function automatic div_part_type div_step(input div_part_type p, input logic [PW-1:0] den);
      div_part_type  r;
      logic [PW-1:0] t;
      logic          ge;
      t = {p.rem[PW-2:0], p.n[SW-1]};
      ge = (t >= den);
      r.rem = ge ? (t - den) : t;
      r.n = {p.n[SW-2:0], 1'b0};
      r.q = {p.q[QW-2:0], ge};
      r.big = p.big | p.q[QW-1];
      return r;
   endfunction

   function automatic sat_type sat_pack(input logic neg, input logic [SW-1:0] mag,
                                        input logic big);
      localparam logic [SW-1:0] LIM_POS = (SW'(1) << (DW - 1)) - SW'(1);
      localparam logic [SW-1:0] LIM_NEG = SW'(1) << (DW - 1);
      sat_type r;
      logic    sat;
      sat = big | (neg ? (mag > LIM_NEG) : (mag > LIM_POS));
      r.ov = sat;
      if (sat) begin
         r.val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         r.val = neg ? (DW'(0) - mag[DW-1:0]) : mag[DW-1:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: design/cau_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module cau_prep import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire req_type  in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output cell_type      out_data
);
   localparam logic [SW-1:0] RND = (SW'(1) << FRAC_BITS) - SW'(1);

   // Stage A: registered request.
   logic    a_v_ff;
   req_type a_ff;
   // Stage B: products (or sign-extended operands for add and subtract).
   logic                 b_v_ff;
   logic [1:0]           b_op_ff;
   logic signed [PW-1:0] xr0_ff, xr1_ff, xi0_ff, xi1_ff, sqr_ff, sqi_ff;
   logic signed [PW-1:0] xr0_in, xr1_in, xi0_in, xi1_in;
   // Stage C: exact sums and the divisor.
   logic                 c_v_ff;
   logic [1:0]           c_op_ff;
   logic signed [SW-1:0] sr_ff, si_ff;
   logic [PW-1:0]        den_ff;
   logic                 sub_re, sub_im;
   logic signed [SW-1:0] sr_in, si_in;
   // Stage D output.
   logic     d_v_ff;
   cell_type d_ff, d_in;
   logic     neg_re, neg_im;
   logic [SW-1:0] mr, mi;

   logic a_rdy, b_rdy, c_rdy, d_rdy;
   assign d_rdy = !d_v_ff || out_ready;
   assign c_rdy = !c_v_ff || d_rdy;
   assign b_rdy = !b_v_ff || c_rdy;
   assign a_rdy = !a_v_ff || b_rdy;
   assign in_ready = a_rdy;

   always_comb begin
      if (a_ff.action == OP_ADD || a_ff.action == OP_SUB) begin
         xr0_in = PW'(a_ff.a_re);
         xr1_in = PW'(a_ff.b_re);
         xi0_in = PW'(a_ff.a_im);
         xi1_in = PW'(a_ff.b_im);
      end else begin
         xr0_in = a_ff.a_re * a_ff.b_re;
         xr1_in = a_ff.a_im * a_ff.b_im;
         xi0_in = a_ff.a_im * a_ff.b_re;
         xi1_in = a_ff.a_re * a_ff.b_im;
      end
   end

   always_comb begin
      sub_re = (b_op_ff == OP_SUB) || (b_op_ff == OP_MUL);
      sub_im = (b_op_ff == OP_SUB) || (b_op_ff == OP_DIV);
      sr_in = sub_re ? (SW'(xr0_ff) - SW'(xr1_ff)) : (SW'(xr0_ff) + SW'(xr1_ff));
      si_in = sub_im ? (SW'(xi0_ff) - SW'(xi1_ff)) : (SW'(xi0_ff) + SW'(xi1_ff));
   end

   always_comb begin
      neg_re = sr_ff[SW-1];
      neg_im = si_ff[SW-1];
      mr = neg_re ? (SW'(0) - sr_ff) : sr_ff;
      mi = neg_im ? (SW'(0) - si_ff) : si_ff;
      d_in.div = (c_op_ff == OP_DIV);
      d_in.dz = (c_op_ff == OP_DIV) && (den_ff == '0);
      d_in.neg_re = neg_re;
      d_in.neg_im = neg_im;
      // A product shifted right arithmetically rounds toward minus infinity.
      if (c_op_ff == OP_MUL) begin
         d_in.mag_re = neg_re ? ((mr + RND) >> FRAC_BITS) : (mr >> FRAC_BITS);
         d_in.mag_im = neg_im ? ((mi + RND) >> FRAC_BITS) : (mi >> FRAC_BITS);
      end else begin
         d_in.mag_re = mr;
         d_in.mag_im = mi;
      end
      d_in.den = den_ff;
      d_in.dre.n = mr;
      d_in.dre.rem = '0;
      d_in.dre.q = '0;
      d_in.dre.big = 1'b0;
      d_in.dim.n = mi;
      d_in.dim.rem = '0;
      d_in.dim.q = '0;
      d_in.dim.big = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (a_rdy) a_v_ff <= in_valid;
         if (b_rdy) b_v_ff <= a_v_ff;
         if (c_rdy) c_v_ff <= b_v_ff;
         if (d_rdy) d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && in_valid) a_ff <= in_data;
      if (b_rdy && a_v_ff) begin
         b_op_ff <= a_ff.action;
         xr0_ff <= xr0_in;
         xr1_ff <= xr1_in;
         xi0_ff <= xi0_in;
         xi1_ff <= xi1_in;
         sqr_ff <= a_ff.b_re * a_ff.b_re;
         sqi_ff <= a_ff.b_im * a_ff.b_im;
      end
      if (c_rdy && b_v_ff) begin
         c_op_ff <= b_op_ff;
         sr_ff <= sr_in;
         si_ff <= si_in;
         den_ff <= unsigned'(sqr_ff) + unsigned'(sqi_ff);
      end
      if (d_rdy && c_v_ff) d_ff <= d_in;
   end

   assign out_valid = d_v_ff;
   assign out_data = d_ff;
endmodule
`default_nettype wire

// File: design/cau_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cau_div_cell import cau_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire cell_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output cell_type      out_data
);
   logic     v_ff;
   cell_type d_ff, d_in;

   assign in_ready = !v_ff || out_ready;

   // Each cell brings one more dividend bit into both remainders.
   always_comb begin
      d_in = in_data;
      d_in.dre = div_step(in_data.dre, in_data.den);
      d_in.dim = div_step(in_data.dim, in_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data = d_ff;
endmodule
`default_nettype wire

// File: design/complex_arith_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data (req_type)
// rsp_      out        rsp_valid / rsp_ready  rsp_data (rsp_type)
//
// One request is taken every cycle while the response is not stalled. The path
// runs through four front stages, one divider cell per quotient bit (2*DW+1+FRAC_BITS
// cells, 41 at the defaults) and the output register.
// Reset clears only the valid flags. A stalled response holds each stage in
// turn; a stage that is empty keeps taking data from the one before it.
`include "complex_arith_unit_core_assert.svh"
module complex_arith_unit_core import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam int NCELL = SW + FRAC_BITS;

   logic     v [NCELL+1];
   logic     r [NCELL+1];
   cell_type d [NCELL+1];

   cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (v[0]),
      .out_ready (r[0]),
      .out_data  (d[0])
   );

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      cau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[k]),
         .in_ready  (r[k]),
         .in_data   (d[k]),
         .out_valid (v[k+1]),
         .out_ready (r[k+1]),
         .out_data  (d[k+1])
      );
   end

   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;
   cell_type last;
   sat_type  pre, pim;

   assign last = d[NCELL];
   assign r[NCELL] = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (last.div) begin
         pre = sat_pack(last.neg_re, SW'(last.dre.q), last.dre.big);
         pim = sat_pack(last.neg_im, SW'(last.dim.q), last.dim.big);
      end else begin
         pre = sat_pack(last.neg_re, last.mag_re, 1'b0);
         pim = sat_pack(last.neg_im, last.mag_im, 1'b0);
      end
      if (last.dz) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.overflow = 1'b0;
      end else begin
         rsp_in.res_re = pre.val;
         rsp_in.res_im = pim.val;
         rsp_in.overflow = pre.ov | pim.ov;
      end
      rsp_in.div_zero = last.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (r[NCELL]) begin
         rsp_valid_ff <= v[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (r[NCELL] && v[NCELL]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `CAU_ASSERT_SAME(a_dz_zero, clock, reset, rsp_valid_ff && rsp_ff.div_zero, rsp_ff.res_re == '0 && rsp_ff.res_im == '0 && !rsp_ff.overflow, "divide by zero gave a nonzero result")
   `CAU_ASSERT_SAME(a_dz_div, clock, reset, v[NCELL] && last.dz, last.div, "zero divisor flagged outside a divide")
   `CAU_ASSERT_NEXT(a_load_out, clock, reset, v[NCELL] && r[NCELL], rsp_valid_ff, "result lost at the output register")
endmodule
`default_nettype wire

// File: tb/complex_arith_unit_checker.sv
`timescale 1ns / 1ps
module complex_arith_unit_checker import cau_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           n_errors,
   output int           n_pending
);
   localparam longint POS_MAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint NEG_MIN = -(64'sd1 <<< (DW - 1));

   rsp_type expected_results[$];

   assign n_pending = expected_results.size();

   function automatic logic [DW-1:0] clamp_part(input longint v, inout logic ov);
      if (v > POS_MAX) begin
         ov = 1'b1;
         return POS_MAX[DW-1:0];
      end
      if (v < NEG_MIN) begin
         ov = 1'b1;
         return NEG_MIN[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Divides with truncation toward zero; the denominator is always positive.
   function automatic longint scaled_quotient(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FRAC_BITS_DEF) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic rsp_type complex_result(input req_type r);
      rsp_type res;
      longint  ar, ai, br, bi, den, vr, vi;
      logic    ov;
      ar = longint'(r.a_re);
      ai = longint'(r.a_im);
      br = longint'(r.b_re);
      bi = longint'(r.b_im);
      ov = 1'b0;
      res.div_zero = 1'b0;
      vr = 0;
      vi = 0;
      case (r.action)
         OP_ADD: begin
            vr = ar + br;
            vi = ai + bi;
         end
         OP_SUB: begin
            vr = ar - br;
            vi = ai - bi;
         end
         OP_MUL: begin
            vr = (ar * br - ai * bi) >>> FRAC_BITS_DEF;
            vi = (ai * br + ar * bi) >>> FRAC_BITS_DEF;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               res.div_zero = 1'b1;
            end else begin
               vr = scaled_quotient(ar * br + ai * bi, den);
               vi = scaled_quotient(ai * br - ar * bi, den);
            end
         end
      endcase
      res.res_re = clamp_part(vr, ov);
      res.res_im = clamp_part(vi, ov);
      res.overflow = ov;
      return res;
   endfunction

   initial n_errors = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(complex_result(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               n_errors <= n_errors + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  n_errors <= n_errors + 1;
               end
            end
         end
      end
   end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb import cau_pkg::*;;
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      n_errors;
   int      n_pending;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   complex_arith_unit_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   complex_arith_unit_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .n_errors(n_errors), .n_pending(n_pending)
   );

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_request(input logic [1:0] op, input logic [DW-1:0] ar,
                               input logic [DW-1:0] ai, input logic [DW-1:0] br,
                               input logic [DW-1:0] bi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{action: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly moderate values, so that results often stay in range.
   function automatic logic [DW-1:0] random_part();
      if ($urandom_range(0, 2) == 0) return DW'($urandom);
      return DW'($urandom_range(0, 2047)) - DW'(1024);
   endfunction

   initial begin
      logic [1:0]    op;
      logic [DW-1:0] br, bi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_request(OP_ADD, 16'h0100, 16'hff00, 16'h0200, 16'h0001);
      send_request(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_request(OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
      send_request(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      send_request(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
      send_request(OP_MUL, 16'h0180, 16'hff40, 16'h0200, 16'h0100);
      send_request(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
      send_request(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
      send_request(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
      send_request(OP_DIV, 16'hff01, 16'h00ff, 16'h0300, 16'hfd00);
      send_request(OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h0000);
      send_request(OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
      send_request(OP_DIV, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int i = 0; i < 460; i++) begin
            op = 2'($urandom_range(0, 3));
            br = random_part();
            bi = random_part();
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
               br = '0;
               bi = '0;
            end
            send_request(op, random_part(), random_part(), br, bi);
         end
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (n_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (n_errors == 0 && n_pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+design
design/cau_pkg.sv
design/cau_prep.sv
design/cau_div_cell.sv
design/complex_arith_unit_core.sv
tb/complex_arith_unit_checker.sv
tb/tb.sv
